// ===== rtl/core/cpf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpf_pkg
// Types and constants shared by the command packet framer.
// ---------------------------------------------------------------------------
package cpf_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned TICK_W     = 16;

  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_CODE_TABLE    = 2'd0;
  localparam logic [1:0] REG_SIZE_TABLE    = 2'd1;
  localparam logic [1:0] REG_TERM_BYTE     = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_NACK     = 2'd0;
  localparam logic [1:0] KIND_BYTE     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_LOOK,
    S_TERM,
    S_RD,
    S_EMIT,
    S_NACK,
    S_OVF,
    S_TICK
  } state_t;

endpackage

// ===== rtl/core/command_packet_framer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_packet_framer_unit
// Ring-buffered byte framer: head-code length lookup, terminator check,
// per-byte packet output, nack on drop, overflow flag and tick watchdog.
// A tick or overflow item goes to its result state, which pushes the result
// into the output register. A stored byte passes store, head read and lookup;
// further head scans, the terminator check and each packet byte all use the
// one ring read port, and every result push waits out any output stall.
// The next item is taken once the scan stalls (buffer empty or short).
// Reset (rst, synchronous): pointers, count, tick counter and registers clear;
// timeout_ticks resets to 1000. Ring contents are not cleared.
// ---------------------------------------------------------------------------
module command_packet_framer_unit
  import cpf_pkg::*;
#(
  parameter int RING_DEPTH = 64,
  parameter int MAX_PACKET = 31,
  parameter int NUM_CODES  = 6
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [7:0]            rx_byte,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [7:0]            data,
  output logic [LEN_W-1:0]      position,
  output logic                  last,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // configuration
  logic [47:0]       code_table;
  logic [29:0]       size_table;
  logic [7:0]        term_byte;
  logic [TICK_W-1:0] timeout_ticks;
  logic              cfg_wr;

  // state
  state_t            state, state_next;
  logic [PTR_W-1:0]  read_pointer, read_pointer_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [TICK_W-1:0] ticks_since_packet, ticks_since_packet_next;
  logic [7:0]        head, head_next;
  logic [LEN_W-1:0]  pkt_len, pkt_len_next;
  logic [LEN_W-1:0]  idx, idx_next;

  // ring memory
  logic [7:0]        ring_store [RING_DEPTH];
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [7:0]        rd_q;

  // lookup
  logic [LEN_W-1:0]  lk_raw, lk_len;

  // result push
  logic              out_free, push, push_last;
  logic [1:0]        push_kind;
  logic [7:0]        push_data;
  logic [LEN_W-1:0]  push_pos;
  logic [TICK_W-1:0] ticks_inc;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = {1'b0, base} + off;
    if (s >= SUM_W'(RING_DEPTH)) begin
      s = s - SUM_W'(RING_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_table    <= '0;
      size_table    <= '0;
      term_byte     <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_CODE_TABLE:    code_table    <= pwdata[47:0];
        REG_SIZE_TABLE:    size_table    <= pwdata[29:0];
        REG_TERM_BYTE:     term_byte     <= pwdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[TICK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_CODE_TABLE:    prdata = CFG_DATA_W'(code_table);
      REG_SIZE_TABLE:    prdata = CFG_DATA_W'(size_table);
      REG_TERM_BYTE:     prdata = CFG_DATA_W'(term_byte);
      REG_TIMEOUT_TICKS: prdata = CFG_DATA_W'(timeout_ticks);
    endcase
  end

  // ---- ring memory ----
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_store[wr_addr] <= head_next;
    end
    if (rd_en) begin
      rd_q <= ring_store[rd_addr];
    end
  end

  // ---- code lookup, lowest matching entry wins ----
  always_comb begin
    lk_raw = '0;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (code_table[8*k +: 8] == rd_q && size_table[5*k +: 5] != '0) begin
        lk_raw = size_table[5*k +: 5];
      end
    end
    if (32'(lk_raw) > MAX_PACKET || 32'(lk_raw) > RING_DEPTH) begin
      lk_len = '0;
    end else begin
      lk_len = lk_raw;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign ticks_inc = (ticks_since_packet == TICK_MAX) ? ticks_since_packet
                                                      : ticks_since_packet + 1'b1;

  // ---- sequencer ----
  always_comb begin
    state_next              = state;
    read_pointer_next       = read_pointer;
    byte_count_next         = byte_count;
    ticks_since_packet_next = ticks_since_packet;
    head_next               = head;
    pkt_len_next            = pkt_len;
    idx_next                = idx;
    wr_en                   = 1'b0;
    wr_addr                 = wrap_add(read_pointer, SUM_W'(byte_count));
    rd_en                   = 1'b0;
    rd_addr                 = read_pointer;
    push                    = 1'b0;
    push_kind               = KIND_NACK;
    push_data               = head;
    push_pos                = '0;
    push_last               = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd) begin
            ticks_since_packet_next = ticks_inc;
            if (ticks_inc >= timeout_ticks) begin
              state_next = S_TICK;
            end
          end else begin
            head_next = rx_byte;
            if (32'(byte_count) >= RING_DEPTH) begin
              state_next = S_OVF;
            end else begin
              wr_en           = 1'b1;
              byte_count_next = byte_count + 1'b1;
              state_next      = S_HEAD;
            end
          end
        end
      end
      S_HEAD: begin
        if (byte_count == '0) begin
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        head_next    = rd_q;
        pkt_len_next = lk_len;
        if (lk_len == '0) begin
          state_next = S_NACK;
        end else if (32'(byte_count) >= 32'(lk_len)) begin
          rd_en      = 1'b1;
          rd_addr    = wrap_add(read_pointer, SUM_W'(lk_len - 1'b1));
          state_next = S_TERM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TERM: begin
        idx_next = '0;
        if (rd_q == term_byte) begin
          state_next = S_RD;
        end else begin
          state_next = S_NACK;
        end
      end
      S_RD: begin
        rd_en      = 1'b1;
        rd_addr    = wrap_add(read_pointer, SUM_W'(idx));
        state_next = S_EMIT;
      end
      S_EMIT: begin
        push_kind = KIND_BYTE;
        push_data = rd_q;
        push_pos  = idx;
        push_last = (idx == pkt_len - 1'b1);
        if (out_free) begin
          push = 1'b1;
          if (push_last) begin
            read_pointer_next       = wrap_add(read_pointer, SUM_W'(pkt_len));
            byte_count_next         = byte_count - CNT_W'(pkt_len);
            ticks_since_packet_next = '0;
            state_next              = S_HEAD;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_NACK: begin
        if (out_free) begin
          push              = 1'b1;
          read_pointer_next = wrap_add(read_pointer, SUM_W'(1));
          byte_count_next   = byte_count - 1'b1;
          state_next        = S_HEAD;
        end
      end
      S_OVF: begin
        push_kind = KIND_OVERFLOW;
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        push_kind = KIND_TIMEOUT;
        push_data = '0;
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      read_pointer       <= '0;
      byte_count         <= '0;
      ticks_since_packet <= '0;
    end else begin
      state              <= state_next;
      read_pointer       <= read_pointer_next;
      byte_count         <= byte_count_next;
      ticks_since_packet <= ticks_since_packet_next;
    end
  end

  always_ff @(posedge clk) begin
    head    <= head_next;
    pkt_len <= pkt_len_next;
    idx     <= idx_next;
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind     <= push_kind;
      data     <= push_data;
      position <= push_pos;
      last     <= push_last;
    end
  end

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(byte_count) <= RING_DEPTH)
    else $error("byte count above ring depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed over a held item");

  a_packet_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    (push && push_kind == KIND_BYTE && push_last) |=> ticks_since_packet == '0)
    else $error("good packet did not clear the watchdog");

  a_full_overflows: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !cmd && 32'(byte_count) == RING_DEPTH)
      |=> state == S_OVF && $stable(byte_count))
    else $error("byte stored into a full ring");

endmodule

// ===== sim/command_packet_framer_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_packet_framer_unit_test
// Self-checking bench for the command packet framer. Bytes and ticks go in
// through the valid/stall port. A built-in framer predicts every nack,
// packet byte and timeout from the same register settings. A checker
// process compares each output item in order. Covers directed corner cases,
// maximum-length packets, watchdog timeouts, randomised framed traffic
// under sender and receiver idling, and a long receiver hold-off.
// ---------------------------------------------------------------------------
module command_packet_framer_unit_test;
  import cpf_pkg::*;

  localparam int RING_DEPTH     = 64;
  localparam int NUM_CODES      = 6;
  localparam int PTR_W          = $clog2(RING_DEPTH);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 45;
  localparam int HOLD_ITEMS     = 10;

  localparam logic [7:0] CODE_A = 8'h61;
  localparam logic [7:0] CODE_B = 8'h62;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] position;
    logic             last;
  } frame_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd      = 1'b0;
  logic [7:0]            rx_byte  = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            data;
  logic [LEN_W-1:0]      position;
  logic                  last;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // framer state as predicted
  logic [7:0]       ring [RING_DEPTH];
  logic [PTR_W-1:0] head_ptr;
  int               held_bytes;
  logic [TICK_W-1:0] idle_ticks;
  logic [47:0]      code_tab;
  logic [29:0]      size_tab;
  logic [7:0]       term_val;
  logic [TICK_W-1:0] timeout_val;

  frame_result_t expected_results[$];
  frame_result_t want_result;
  int unsigned   fail_count     = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   items_sent     = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  logic          hold_rx        = 1'b0;

  command_packet_framer_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .data(data),
    .position(position), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic void add_frame_result(input logic [1:0] k, input logic [7:0] d,
                                           input logic [LEN_W-1:0] p, input logic l);
    expected_results.push_back(frame_result_t'{kind: k, data: d, position: p, last: l});
  endfunction

  // lowest enabled entry matching the head wins; 0 means unknown
  function automatic int packet_len(input logic [7:0] head);
    for (int k = 0; k < NUM_CODES; k++) begin
      if (code_tab[8*k +: 8] == head && size_tab[LEN_W*k +: LEN_W] != '0) begin
        return int'(size_tab[LEN_W*k +: LEN_W]);
      end
    end
    return 0;
  endfunction

  task automatic predict_item(input logic is_tick, input logic [7:0] value);
    int               len;
    logic [7:0]       head;
    logic [PTR_W-1:0] slot;
    if (is_tick) begin
      if (idle_ticks != TICK_MAX) idle_ticks++;
      if (idle_ticks >= timeout_val) add_frame_result(KIND_TIMEOUT, 8'h00, '0, 1'b0);
      return;
    end
    if (held_bytes >= RING_DEPTH) begin
      add_frame_result(KIND_OVERFLOW, value, '0, 1'b0);
      return;
    end
    slot = PTR_W'(head_ptr + held_bytes);
    ring[slot] = value;
    held_bytes++;
    while (held_bytes > 0) begin
      head = ring[head_ptr];
      len  = packet_len(head);
      slot = PTR_W'(head_ptr + len - 1);
      if (len != 0 && held_bytes >= len && ring[slot] == term_val) begin
        for (int i = 0; i < len; i++) begin
          slot = PTR_W'(head_ptr + i);
          add_frame_result(KIND_BYTE, ring[slot], i[LEN_W-1:0], i == len - 1);
        end
        head_ptr   = PTR_W'(head_ptr + len);
        held_bytes = held_bytes - len;
        idle_ticks = '0;
      end else if (len == 0 || held_bytes >= len) begin
        add_frame_result(KIND_NACK, head, '0, 1'b0);
        head_ptr = head_ptr + 1'b1;
        held_bytes--;
      end else begin
        break;
      end
    end
  endtask

  task automatic send_item(input logic is_tick, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= is_tick;
    rx_byte  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_item(is_tick, value);
  endtask

  // one framed packet for a random table entry; a bad one has a wrong terminator
  task automatic send_packet(input bit good);
    int         k;
    int         len;
    logic [7:0] flip;
    k   = $urandom_range(NUM_CODES - 1);
    len = int'(size_tab[LEN_W*k +: LEN_W]);
    if (len == 0) begin
      send_item(1'b0, 8'($urandom_range(255)));
      return;
    end
    send_item(1'b0, code_tab[8*k +: 8]);
    for (int i = 1; i < len - 1; i++) send_item(1'b0, 8'($urandom_range(255)));
    if (len > 1) begin
      flip = 8'($urandom_range(1, 255));
      send_item(1'b0, good ? term_val : term_val ^ flip);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_CODE_TABLE:    code_tab    = value[47:0];
      REG_SIZE_TABLE:    size_tab    = value[29:0];
      REG_TERM_BYTE:     term_val    = value[7:0];
      REG_TIMEOUT_TICKS: timeout_val = value[TICK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_setup(input logic [47:0] codes, input logic [29:0] sizes,
                             input logic [7:0] term, input logic [TICK_W-1:0] limit);
    write_reg(REG_CODE_TABLE, {16'h0000, codes});
    write_reg(REG_SIZE_TABLE, {34'h0, sizes});
    write_reg(REG_TERM_BYTE, {56'h0, term});
    write_reg(REG_TIMEOUT_TICKS, {48'h0, limit});
  endtask

  task automatic pick_random_setup;
    logic [47:0]       codes;
    logic [29:0]       sizes;
    logic [7:0]        term;
    logic [TICK_W-1:0] limit;
    int                r;
    for (int k = 0; k < NUM_CODES; k++) begin
      r = $urandom_range(9);
      codes[8*k +: 8] = (r == 0) ? CODE_A : (r == 1) ? CODE_B : 8'($urandom_range(255));
      r = $urandom_range(9);
      sizes[LEN_W*k +: LEN_W] = (r == 0) ? 5'd0 :
                                (r == 1) ? 5'($urandom_range(9, 31)) :
                                5'($urandom_range(1, 8));
    end
    r    = $urandom_range(3);
    term = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
    limit = ($urandom_range(3) == 0) ? 16'($urandom_range(1000, 65535)) :
                                       16'($urandom_range(1, 24));
    write_setup(codes, sizes, term, limit);
  endtask

  task automatic test_directed;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset tables: everything is unknown, one tick stays under the limit
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'hA5);
    drain();
    // entry 0 disabled, two 'b' entries (lower wins), 0xFF a one-byte packet
    write_setup(48'hFF_00_62_62_61_10, {5'd1, 5'd31, 5'd5, 5'd2, 5'd3, 5'd0},
                8'hFF, 16'd1);
    send_item(1'b0, CODE_A);
    send_item(1'b0, 8'h41);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    send_item(1'b0, CODE_B);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CODE_B);
    send_item(1'b0, 8'h10);
    // missing terminator: head dropped, rescan from the next byte
    send_item(1'b0, CODE_A);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h02);
    send_item(1'b0, CODE_A);
    send_item(1'b0, CODE_B);
    send_item(1'b0, 8'h33);
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h5A);
    // head of a 31-byte packet, left waiting for its body
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
    drain();
  endtask

  task automatic test_long_packets;
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    write_setup(48'hFFFF_FFFF_FFFF, 30'h3FFF_FFFF, 8'h00, 16'd65535);
    send_packet(1'b1);
    send_packet(1'b0);
    send_packet(1'b1);
    drain();
  endtask

  // ticks run past a small limit, a good packet clears the count, zero flags all
  task automatic test_watchdog;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_setup(48'h00_00_00_00_00_61, {25'd0, 5'd2}, 8'h7E, 16'd3);
    repeat (5) send_item(1'b1, 8'h00);
    send_item(1'b0, CODE_A);
    send_item(1'b0, 8'h7E);
    repeat (4) send_item(1'b1, 8'hC3);
    drain();
    write_reg(REG_TIMEOUT_TICKS, {48'h0, 16'd0});
    repeat (2) send_item(1'b1, 8'h00);
    drain();
  endtask

  task automatic test_random_traffic;
    int          roll;
    int unsigned stop_at;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      pick_random_setup();
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          send_packet(roll < 60);
        end else if (roll < 85) begin
          send_item(1'b0, 8'($urandom_range(255)));
        end else begin
          send_item(1'b1, 8'($urandom_range(255)));
        end
      end
      drain();
    end
  endtask

  task automatic test_receiver_hold_off;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pick_random_setup();
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
      repeat (HOLD_ITEMS) send_packet(1'b1);
    join
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d data %02h pos %0d last %0d",
                                  kind, data, position, last));
      end else begin
        want_result = expected_results.pop_front();
        if (kind !== want_result.kind || data !== want_result.data ||
            position !== want_result.position || last !== want_result.last) begin
          report_mismatch($sformatf(
            "got kind %0d data %02h pos %0d last %0d, want %0d %02h %0d %0d",
            kind, data, position, last, want_result.kind,
            want_result.data, want_result.position, want_result.last));
        end
      end
    end
    out_stall <= hold_rx || ($urandom_range(99) < recv_stall_pct);
  end

  // ends the run if neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    head_ptr    = '0;
    held_bytes  = 0;
    idle_ticks  = '0;
    code_tab    = '0;
    size_tab    = '0;
    term_val    = 8'h00;
    timeout_val = TIMEOUT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_packets();
    test_watchdog();
    test_random_traffic();
    test_receiver_hold_off();
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d items never arrived", expected_results.size()));
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cpf_pkg.sv
rtl/core/command_packet_framer_unit.sv
sim/command_packet_framer_unit_test.sv
